// ===== hdl/wfl_pkg.sv =====
// ----------------------------------------------------------------------------
// wfl_pkg
// Shared types, codes and direction helpers of the maze wall follower.
// ----------------------------------------------------------------------------
`default_nettype none

package wfl_pkg;

  // Grid geometry: square grid, one bit per cell (1 open, 0 wall)
  localparam int GridSize = 16;
  localparam int CoordW   = 4;

  typedef logic [CoordW-1:0] coord_t;

  localparam coord_t CoordMin = '0;
  localparam coord_t CoordMax = CoordW'(GridSize - 1);

  // Request command codes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PLACE = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Walker heading
  typedef enum logic [2:0] {
    HD_NONE  = 3'd0,
    HD_UP    = 3'd1,
    HD_DOWN  = 3'd2,
    HD_LEFT  = 3'd3,
    HD_RIGHT = 3'd4
  } hd_e;

  // Result status; also used for the finished flag (OK means still walking)
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WALK  = 2'd1,
    ST_EXIT  = 2'd2,
    ST_STUCK = 2'd3
  } st_e;

  // Request payload
  typedef struct packed {
    cmd_e   cmd;
    coord_t row;
    coord_t col;
    logic   open;
  } req_t;

  // Result payload
  typedef struct packed {
    coord_t pos_row;
    coord_t pos_col;
    hd_e    heading;
    st_e    status;
  } res_t;

  // Open flags of the four neighbours of the walker (outside the grid = wall)
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nb_t;

  function automatic hd_e right_of(hd_e h);
    case (h)
      HD_UP:    return HD_RIGHT;
      HD_DOWN:  return HD_LEFT;
      HD_LEFT:  return HD_UP;
      HD_RIGHT: return HD_DOWN;
      default:  return HD_NONE;
    endcase
  endfunction

  function automatic hd_e left_of(hd_e h);
    case (h)
      HD_UP:    return HD_LEFT;
      HD_DOWN:  return HD_RIGHT;
      HD_LEFT:  return HD_DOWN;
      HD_RIGHT: return HD_UP;
      default:  return HD_NONE;
    endcase
  endfunction

  function automatic hd_e back_of(hd_e h);
    case (h)
      HD_UP:    return HD_DOWN;
      HD_DOWN:  return HD_UP;
      HD_LEFT:  return HD_RIGHT;
      HD_RIGHT: return HD_LEFT;
      default:  return HD_NONE;
    endcase
  endfunction

  // Open flag of the neighbour in direction d
  function automatic logic nb_sel(nb_t nb, hd_e d);
    case (d)
      HD_UP:    return nb.up;
      HD_DOWN:  return nb.down;
      HD_LEFT:  return nb.left;
      HD_RIGHT: return nb.right;
      default:  return 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/wfl_if.sv =====
// ----------------------------------------------------------------------------
// wfl_req_if / wfl_rsp_if
// Valid/ready channels for walker requests and walker results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wfl_req_if;
  import wfl_pkg::*;

  logic   valid;
  logic   ready;
  cmd_e   cmd;
  coord_t row;
  coord_t col;
  logic   open;

  modport source (output valid, cmd, row, col, open, input ready);
  modport sink   (input valid, cmd, row, col, open, output ready);
endinterface

interface wfl_rsp_if;
  import wfl_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pos_row;
  coord_t pos_col;
  hd_e    heading;
  st_e    status;

  modport source (output valid, pos_row, pos_col, heading, status, input ready);
  modport sink   (input valid, pos_row, pos_col, heading, status, output ready);
endinterface

`default_nettype wire

// ===== hdl/wfl_grid.sv =====
// ----------------------------------------------------------------------------
// wfl_grid
// Cell store. Kept twice, as row words and as column words, so the four
// neighbours of the walker come from one word of each copy.
// ----------------------------------------------------------------------------
`default_nettype none

module wfl_grid (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire wfl_pkg::coord_t wr_row_i,
  input  wire wfl_pkg::coord_t wr_col_i,
  input  wire logic            wr_open_i,
  input  wire wfl_pkg::coord_t pos_row_i,
  input  wire wfl_pkg::coord_t pos_col_i,
  output wfl_pkg::nb_t         nb_o
);
  import wfl_pkg::*;

  logic [GridSize-1:0] row_mem_q [GridSize];
  logic [GridSize-1:0] col_mem_q [GridSize];
  logic [GridSize-1:0] row_word;
  logic [GridSize-1:0] col_word;

  // Cell write, mirrored into both copies; contents undefined until loaded
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      row_mem_q[wr_row_i][wr_col_i] <= wr_open_i;
      col_mem_q[wr_col_i][wr_row_i] <= wr_open_i;
    end
  end

  // Walker's row word gives left/right, its column word gives up/down
  assign row_word = row_mem_q[pos_row_i];
  assign col_word = col_mem_q[pos_col_i];

  // Neighbours beyond the border read as wall
  always_comb begin
    nb_o.up    = (pos_row_i != CoordMin) && col_word[pos_row_i - coord_t'(1)];
    nb_o.down  = (pos_row_i != CoordMax) && col_word[pos_row_i + coord_t'(1)];
    nb_o.left  = (pos_col_i != CoordMin) && row_word[pos_col_i - coord_t'(1)];
    nb_o.right = (pos_col_i != CoordMax) && row_word[pos_col_i + coord_t'(1)];
  end

endmodule

`default_nettype wire

// ===== hdl/wfl_walker.sv =====
// ----------------------------------------------------------------------------
// wfl_walker
// Walker state and the right-hand rule: one move or turn per step request.
// ----------------------------------------------------------------------------
`default_nettype none

module wfl_walker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire wfl_pkg::req_t  req_i,
  input  wire wfl_pkg::nb_t   nb_i,
  output wfl_pkg::coord_t     pos_row_o,
  output wfl_pkg::coord_t     pos_col_o,
  output wfl_pkg::res_t       res_o
);
  import wfl_pkg::*;

  coord_t row_q, row_d;
  coord_t col_q, col_d;
  hd_e    hd_q, hd_d;
  logic   first_q, first_d;
  st_e    fin_q, fin_d;

  st_e    status;
  logic   mv;
  hd_e    mv_dir;
  coord_t mv_row;
  coord_t mv_col;

  // Next state
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    hd_d    = hd_q;
    first_d = first_q;
    fin_d   = fin_q;
    status  = ST_OK;
    mv      = 1'b0;
    mv_dir  = HD_NONE;
    mv_row  = row_q;
    mv_col  = col_q;

    if (en_i) begin
      case (req_i.cmd)
        CMD_PLACE: begin
          row_d   = req_i.row;
          col_d   = req_i.col;
          hd_d    = HD_NONE;
          first_d = 1'b1;
          fin_d   = ST_OK;
        end
        CMD_STEP: begin
          if (fin_q != ST_OK) begin
            // walk over: repeat final status
            status = fin_q;
          end else if (first_q ||
                       !(hd_q inside {HD_UP, HD_DOWN, HD_LEFT, HD_RIGHT})) begin
            // first step: down, up, left, right
            mv = 1'b1;
            if (nb_i.down) begin
              mv_dir = HD_DOWN;
            end else if (nb_i.up) begin
              mv_dir = HD_UP;
            end else if (nb_i.left) begin
              mv_dir = HD_LEFT;
            end else if (nb_i.right) begin
              mv_dir = HD_RIGHT;
            end else begin
              mv     = 1'b0;
              fin_d  = ST_STUCK;
              status = ST_STUCK;
            end
          end else if (nb_sel(nb_i, right_of(hd_q))) begin
            mv     = 1'b1;
            mv_dir = right_of(hd_q);
          end else if (nb_sel(nb_i, hd_q)) begin
            mv     = 1'b1;
            mv_dir = hd_q;
          end else if (nb_sel(nb_i, left_of(hd_q))) begin
            hd_d   = left_of(hd_q);
            status = ST_WALK;
          end else begin
            hd_d   = back_of(hd_q);
            status = ST_WALK;
          end
        end
        default: ;
      endcase
    end

    // One-cell move and border exit check
    case (mv_dir)
      HD_UP:    mv_row = row_q - coord_t'(1);
      HD_DOWN:  mv_row = row_q + coord_t'(1);
      HD_LEFT:  mv_col = col_q - coord_t'(1);
      HD_RIGHT: mv_col = col_q + coord_t'(1);
      default:  ;
    endcase

    if (mv) begin
      row_d   = mv_row;
      col_d   = mv_col;
      hd_d    = mv_dir;
      first_d = 1'b0;
      if (mv_row == CoordMin || mv_col == CoordMin ||
          mv_row == CoordMax || mv_col == CoordMax) begin
        fin_d  = ST_EXIT;
        status = ST_EXIT;
      end else begin
        status = ST_WALK;
      end
    end
  end

  // Walker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      hd_q    <= HD_NONE;
      first_q <= 1'b1;
      fin_q   <= ST_OK;
    end else if (en_i) begin
      row_q   <= row_d;
      col_q   <= col_d;
      hd_q    <= hd_d;
      first_q <= first_d;
      fin_q   <= fin_d;
    end
  end

  assign pos_row_o = row_q;
  assign pos_col_o = col_q;

  // Result reflects the state after this request
  always_comb begin
    res_o.pos_row = row_d;
    res_o.pos_col = col_d;
    res_o.heading = hd_d;
    res_o.status  = status;
  end

endmodule

`default_nettype wire

// ===== hdl/maze_wall_follower.sv =====
// ----------------------------------------------------------------------------
// maze_wall_follower
// Right-hand wall follower on a 16 x 16 grid of open and wall cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: cmd (load a cell, place the walker, take a
//   step, or no-op), row, col and open. rsp_o returns exactly one result per
//   request, in order: walker position, heading and status.
//   Cells must be loaded before the walker reads them; a place request puts
//   the walker on its start cell with no heading.
// Path and throughput:
//   A request is held in the input register, is processed in one pass through
//   the cell store and the step logic, and its result is registered in the
//   output register, which drives rsp_o. One request per cycle is sustained
//   while rsp_o is not held off.
// Reset:
//   Walker at row 0, column 0, no heading, first step armed, walk not ended.
//   Both pipeline registers empty. Cell contents are not cleared.
// Stalls:
//   When rsp_o is held off, the result stays in the output register; one more
//   request may wait in the input register, after which req_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_wall_follower (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wfl_req_if.sink    req_i,
  wfl_rsp_if.source  rsp_o
);
  import wfl_pkg::*;

  logic   in_vld_q;
  req_t   in_q;
  logic   out_vld_q;
  res_t   out_q;
  logic   adv;
  nb_t    nb;
  coord_t pos_row;
  coord_t pos_col;
  res_t   res_d;

  // Request in the input register moves on when the output register is free
  assign adv         = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.cmd  <= req_i.cmd;
      in_q.row  <= req_i.row;
      in_q.col  <= req_i.col;
      in_q.open <= req_i.open;
    end
  end

  wfl_grid u_grid (
    .clk_i     (clk_i),
    .we_i      (adv && (in_q.cmd == CMD_LOAD)),
    .wr_row_i  (in_q.row),
    .wr_col_i  (in_q.col),
    .wr_open_i (in_q.open),
    .pos_row_i (pos_row),
    .pos_col_i (pos_col),
    .nb_o      (nb)
  );

  wfl_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .req_i     (in_q),
    .nb_i      (nb),
    .pos_row_o (pos_row),
    .pos_col_o (pos_col),
    .res_o     (res_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.pos_row = out_q.pos_row;
  assign rsp_o.pos_col = out_q.pos_col;
  assign rsp_o.heading = out_q.heading;
  assign rsp_o.status  = out_q.status;

endmodule

`default_nettype wire

// ===== hdl/wfl_checker.sv =====
// ----------------------------------------------------------------------------
// wfl_checker
// Port-level checks on the walker results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wfl_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            rsp_valid_i,
  input wire logic            rsp_ready_i,
  input wire wfl_pkg::coord_t rsp_row_i,
  input wire wfl_pkg::coord_t rsp_col_i,
  input wire wfl_pkg::hd_e    rsp_hd_i,
  input wire wfl_pkg::st_e    rsp_st_i
);
  import wfl_pkg::*;

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_row_i) &&
      $stable(rsp_col_i) && $stable(rsp_hd_i) && $stable(rsp_st_i))
    else $error("result changed while stalled");

  // Exit is only reported on the border
  a_exit_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_st_i == ST_EXIT |->
      rsp_row_i == CoordMin || rsp_col_i == CoordMin ||
      rsp_row_i == CoordMax || rsp_col_i == CoordMax)
    else $error("exit reported off the border");

  // Stuck only arises before any move, so there is no heading
  a_stuck_nohd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_st_i == ST_STUCK |-> rsp_hd_i == HD_NONE)
    else $error("stuck with a heading");

  // Every walking step leaves a heading
  a_walk_hd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_st_i == ST_WALK |-> rsp_hd_i != HD_NONE)
    else $error("walking without a heading");

endmodule

bind maze_wall_follower wfl_checker u_wfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_row_i   (rsp_o.pos_row),
  .rsp_col_i   (rsp_o.pos_col),
  .rsp_hd_i    (rsp_o.heading),
  .rsp_st_i    (rsp_o.status)
);

`default_nettype wire
